// ===== sv/oths_pkg.sv =====
// ----------------------------------------------------------------------------
// oths_pkg: shared definitions for the ordered table hunt search
// Field widths, register indexes, transaction payloads and the control store
// of the search sequencer.
// ----------------------------------------------------------------------------
package oths_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 2048;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned ENTRY_W    = 11;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned LIMIT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST    = SIZE_W'(2048);
  localparam logic [SIZE_W-1:0]  WINDOW_POINTS_RST = SIZE_W'(2);
  localparam logic [LIMIT_W-1:0] CORR_LIMIT_RST    = LIMIT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SIZE    = 2'd0,
    CFG_WINDOW_POINTS = 2'd1,
    CFG_CORR_LIMIT    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    logic                     func;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [KEY_W-1:0]  key_value;
  } req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] window_start;
    logic [ENTRY_W-1:0] bracket_index;
    logic               used_hunt;
    logic               size_error;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
  } cfg_t;

  // Sequencer steps, in control store order.
  typedef enum logic [3:0] {
    ST_CHECK   = 4'd0,
    ST_LATCH   = 4'd1,
    ST_ORDER   = 4'd2,
    ST_HUNT    = 4'd3,
    ST_DN_STEP = 4'd4,
    ST_DN_TEST = 4'd5,
    ST_BISECT  = 4'd6,
    ST_BIS_UPD = 4'd7,
    ST_FINISH  = 4'd8,
    ST_UP_STEP = 4'd9,
    ST_UP_TEST = 4'd10,
    ST_UP_EXIT = 4'd11
  } step_e;

  typedef enum logic [2:0] {
    ADDR_LAST  = 3'd0,
    ADDR_FIRST = 3'd1,
    ADDR_SAVED = 3'd2,
    ADDR_UP    = 3'd3,
    ADDR_DOWN  = 3'd4,
    ADDR_MID   = 3'd5
  } addr_sel_e;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_CHECK      = 4'd1,
    OP_LATCH_LAST = 4'd2,
    OP_SET_ASC    = 4'd3,
    OP_HUNT_INIT  = 4'd4,
    OP_UP_STEP    = 4'd5,
    OP_UP_TEST    = 4'd6,
    OP_DN_STEP    = 4'd7,
    OP_DN_TEST    = 4'd8,
    OP_MID        = 4'd9,
    OP_BIS_UPD    = 4'd10,
    OP_FINISH     = 4'd11
  } uop_e;

  typedef enum logic [3:0] {
    COND_NEXT     = 4'd0,
    COND_ALWAYS   = 4'd1,
    COND_SIZE_ERR = 4'd2,
    COND_NO_HUNT  = 4'd3,
    COND_PAST     = 4'd4,
    COND_NOT_PAST = 4'd5,
    COND_UP_END   = 4'd6,
    COND_DN_END   = 4'd7,
    COND_NARROW   = 4'd8
  } cond_e;

  typedef struct packed {
    addr_sel_e addr;
    uop_e      op;
    cond_e     cond;
    step_e     target;
    logic      last;
  } uword_t;

  // Control store. When the condition holds the sequencer jumps to target,
  // otherwise it moves to the next step; a word marked last ends the search.
  function automatic uword_t ucode(step_e step);
    uword_t w;
    case (step)
      ST_CHECK:   w = '{ADDR_LAST,  OP_CHECK,      COND_SIZE_ERR, ST_FINISH,  1'b0};
      ST_LATCH:   w = '{ADDR_FIRST, OP_LATCH_LAST, COND_NEXT,     ST_CHECK,   1'b0};
      ST_ORDER:   w = '{ADDR_SAVED, OP_SET_ASC,    COND_NO_HUNT,  ST_BISECT,  1'b0};
      ST_HUNT:    w = '{ADDR_SAVED, OP_HUNT_INIT,  COND_PAST,     ST_UP_STEP, 1'b0};
      ST_DN_STEP: w = '{ADDR_DOWN,  OP_DN_STEP,    COND_DN_END,   ST_BISECT,  1'b0};
      ST_DN_TEST: w = '{ADDR_DOWN,  OP_DN_TEST,    COND_NOT_PAST, ST_DN_STEP, 1'b0};
      ST_BISECT:  w = '{ADDR_MID,   OP_MID,        COND_NARROW,   ST_FINISH,  1'b0};
      ST_BIS_UPD: w = '{ADDR_MID,   OP_BIS_UPD,    COND_ALWAYS,   ST_BISECT,  1'b0};
      ST_FINISH:  w = '{ADDR_MID,   OP_FINISH,     COND_NEXT,     ST_CHECK,   1'b1};
      ST_UP_STEP: w = '{ADDR_UP,    OP_UP_STEP,    COND_UP_END,   ST_BISECT,  1'b0};
      ST_UP_TEST: w = '{ADDR_UP,    OP_UP_TEST,    COND_PAST,     ST_UP_STEP, 1'b0};
      ST_UP_EXIT: w = '{ADDR_MID,   OP_NONE,       COND_ALWAYS,   ST_BISECT,  1'b0};
      default:    w = '{ADDR_MID,   OP_NONE,       COND_NEXT,     ST_CHECK,   1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/oths_stream_if.sv =====
// ----------------------------------------------------------------------------
// oths_stream_if: valid/ready channel
// Carries one payload per transaction; the source drives valid and data,
// the sink drives ready.
// ----------------------------------------------------------------------------
interface oths_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== sv/ordered_table_hunt_search_top.sv =====
// ----------------------------------------------------------------------------
// ordered_table_hunt_search_top: ordered key table with hunt and bisection
// Keys are loaded one entry per transaction; a query returns the lower
// bracketing index and the clamped start of an interpolation window.
// ----------------------------------------------------------------------------
// A write transaction stores its key and produces no result; the block
// stays ready for the next item. A query runs a microcoded search in which
// every step issues one table read: a size check with reads of the last
// and first entries, a hunt start, hunt steps of a step and a test each
// (plus an exit step on the upward hunt), bisection steps of a midpoint and
// an update each, and a finish. The result sits in an output register; the
// next query is accepted the cycle after the search finishes, while that
// result may still be waiting. A query with invalid sizes skips the search
// and returns with size_error set.
module ordered_table_hunt_search_top
  import oths_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  oths_stream_if.sink          req_i,
  oths_stream_if.source        rsp_o,
  oths_stream_if.sink          cfg_i
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  // Configuration registers.
  logic [SIZE_W-1:0]  table_size_q;
  logic [SIZE_W-1:0]  window_points_q;
  logic [LIMIT_W-1:0] corr_limit_q;

  // Sequencer and persistent search state.
  logic        busy_q, busy_d;
  step_e       pc_q, pc_d;
  logic [SIZE_W-1:0] saved_q;
  logic        corr_q;

  // Datapath registers.
  logic signed [KEY_W-1:0] x_q;
  logic signed [KEY_W-1:0] last_key_q;
  logic signed [KEY_W-1:0] rd_key_q;
  logic        asc_q;
  logic        err_q;
  logic        hunt_q;
  logic [SIZE_W-1:0] jl_q;
  logic [SIZE_W-1:0] ju_q;
  logic [SIZE_W-1:0] jm_q;
  logic [SIZE_W:0]   inc_q;

  logic        out_valid_q;
  rsp_t        out_data_q;

  logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];

  // Control decode and datapath nets.
  uword_t      cw;
  logic        taken;
  logic        req_acc;
  logic        query_acc;
  logic        mem_we;
  logic        out_free;
  logic        out_load;
  logic        size_err;
  logic        past;
  logic        hunt_ok;
  logic        up_end;
  logic        dn_end;
  logic        narrow;
  logic [SIZE_W-1:0]   n_m1;
  logic [SIZE_W+1:0]   up_sum;
  logic signed [SIZE_W+1:0] dn_diff;
  logic [SIZE_W:0]     mid_sum;
  logic [SIZE_W-1:0]   jm_next;
  logic [SIZE_W-1:0]   rd_pos;
  logic [AddrW-1:0]    rd_addr;
  logic [SIZE_W-1:0]   jump_dist;
  logic                corr_next;
  logic [SIZE_W-1:0]   half_win;
  logic [SIZE_W-1:0]   ws_hi;
  logic signed [SIZE_W:0] ws_raw;
  logic [SIZE_W-1:0]   ws;

  assign req_i.ready = ~busy_q;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  assign req_acc   = req_i.valid & req_i.ready;
  assign query_acc = req_acc & (req_i.data.func == FUNC_QUERY);
  assign mem_we    = req_acc & (req_i.data.func == FUNC_WRITE)
                   & (32'(req_i.data.entry_index) < TABLE_DEPTH);

  assign out_free = ~out_valid_q | rsp_o.ready;

  // Datapath arithmetic.
  assign n_m1     = table_size_q - SIZE_W'(1);
  assign size_err = (table_size_q < SIZE_W'(2)) | (window_points_q < SIZE_W'(2))
                  | (window_points_q > table_size_q)
                  | (32'(table_size_q) > TABLE_DEPTH);
  assign past     = ((x_q >= rd_key_q) == asc_q);
  assign hunt_ok  = corr_q & (saved_q <= n_m1);
  assign up_sum   = {2'b00, jl_q} + {1'b0, inc_q};
  assign up_end   = (up_sum >= {2'b00, n_m1});
  assign dn_diff  = $signed({2'b00, jl_q}) - $signed({1'b0, inc_q});
  assign dn_end   = dn_diff[SIZE_W+1] | (dn_diff == '0);
  assign narrow   = ((ju_q - jl_q) <= SIZE_W'(1));
  assign mid_sum  = {1'b0, ju_q} + {1'b0, jl_q};
  assign jm_next  = mid_sum[SIZE_W:1];

  assign jump_dist = (jl_q >= saved_q) ? (jl_q - saved_q) : (saved_q - jl_q);
  assign corr_next = (jump_dist <= SIZE_W'(corr_limit_q));
  assign half_win  = (window_points_q - SIZE_W'(2)) >> 1;
  assign ws_hi     = table_size_q - window_points_q;
  assign ws_raw    = $signed({1'b0, jl_q}) - $signed({1'b0, half_win});

  always_comb begin
    if (ws_raw[SIZE_W]) begin
      ws = '0;
    end else if (ws_raw[SIZE_W-1:0] > ws_hi) begin
      ws = ws_hi;
    end else begin
      ws = ws_raw[SIZE_W-1:0];
    end
  end

  // Control word decode: read address and branch condition.
  always_comb begin
    cw = ucode(pc_q);
    case (cw.cond)
      COND_NEXT:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_SIZE_ERR: taken = size_err;
      COND_NO_HUNT:  taken = ~hunt_ok;
      COND_PAST:     taken = past;
      COND_NOT_PAST: taken = ~past;
      COND_UP_END:   taken = up_end;
      COND_DN_END:   taken = dn_end;
      COND_NARROW:   taken = narrow;
      default:       taken = 1'b0;
    endcase
    case (cw.addr)
      ADDR_LAST:  rd_pos = n_m1;
      ADDR_FIRST: rd_pos = '0;
      ADDR_SAVED: rd_pos = saved_q;
      ADDR_UP:    rd_pos = up_sum[SIZE_W-1:0];
      ADDR_DOWN:  rd_pos = dn_diff[SIZE_W-1:0];
      ADDR_MID:   rd_pos = jm_next;
      default:    rd_pos = '0;
    endcase
    rd_addr  = AddrW'(rd_pos);
    out_load = busy_q & (cw.op == OP_FINISH) & out_free;
  end

  // Sequencer next step.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (query_acc) begin
        busy_d = 1'b1;
        pc_d   = ST_CHECK;
      end
    end else if (cw.last) begin
      if (out_free) begin
        busy_d = 1'b0;
      end
    end else if (taken) begin
      pc_d = cw.target;
    end else begin
      pc_d = step_e'(pc_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b0;
      pc_q            <= ST_CHECK;
      saved_q         <= '0;
      corr_q          <= 1'b0;
      out_valid_q     <= 1'b0;
      table_size_q    <= TABLE_SIZE_RST;
      window_points_q <= WINDOW_POINTS_RST;
      corr_limit_q    <= CORR_LIMIT_RST;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // A query with invalid sizes leaves the search state alone.
      if (out_load && !err_q) begin
        saved_q <= jl_q;
        corr_q  <= corr_next;
      end
      if (cfg_i.valid) begin
        case (cfg_i.data.reg_index)
          CFG_TABLE_SIZE:    table_size_q    <= cfg_i.data.reg_value[SIZE_W-1:0];
          CFG_WINDOW_POINTS: window_points_q <= cfg_i.data.reg_value[SIZE_W-1:0];
          CFG_CORR_LIMIT:    corr_limit_q    <= cfg_i.data.reg_value[LIMIT_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  // Search datapath, driven by the current control word.
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      x_q    <= req_i.data.key_value;
      hunt_q <= 1'b0;
    end
    if (busy_q) begin
      case (cw.op)
        OP_CHECK:      err_q <= size_err;
        OP_LATCH_LAST: last_key_q <= rd_key_q;
        OP_SET_ASC: begin
          asc_q <= (last_key_q >= rd_key_q);
          jl_q  <= '0;
          ju_q  <= n_m1;
        end
        OP_HUNT_INIT: begin
          jl_q   <= saved_q;
          ju_q   <= saved_q;
          inc_q  <= (SIZE_W+1)'(1);
          hunt_q <= 1'b1;
        end
        OP_UP_STEP: ju_q <= up_end ? n_m1 : up_sum[SIZE_W-1:0];
        OP_UP_TEST: begin
          if (past) begin
            jl_q  <= ju_q;
            inc_q <= {inc_q[SIZE_W-1:0], 1'b0};
          end
        end
        OP_DN_STEP: jl_q <= dn_end ? '0 : dn_diff[SIZE_W-1:0];
        OP_DN_TEST: begin
          if (!past) begin
            ju_q  <= jl_q;
            inc_q <= {inc_q[SIZE_W-1:0], 1'b0};
          end
        end
        OP_MID: jm_q <= jm_next;
        OP_BIS_UPD: begin
          if (past) begin
            jl_q <= jm_q;
          end else begin
            ju_q <= jm_q;
          end
        end
        default: ;
      endcase
    end
    if (out_load) begin
      if (err_q) begin
        out_data_q <= '{window_start: '0, bracket_index: '0,
                        used_hunt: 1'b0, size_error: 1'b1};
      end else begin
        out_data_q <= '{window_start: ENTRY_W'(ws), bracket_index: ENTRY_W'(jl_q),
                        used_hunt: hunt_q, size_error: 1'b0};
      end
    end
  end

  // Key table: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[AddrW'(req_i.data.entry_index)] <= req_i.data.key_value;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[rd_addr];
  end

endmodule

// ===== sv/oths_checker.sv =====
// ----------------------------------------------------------------------------
// oths_checker: port-level checks for the ordered table hunt search
// Watches the query and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module oths_checker
  import oths_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               req_func_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [ENTRY_W-1:0] window_start_i,
  input logic [ENTRY_W-1:0] bracket_index_i,
  input logic               used_hunt_i,
  input logic               size_error_i
);

  // A query transaction occupies the sequencer, so no item is taken next.
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_func_i == FUNC_QUERY) |=> !req_ready_i)
    else $error("input accepted right after a query");

  // The window never starts past the bracketing index.
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !size_error_i |-> (window_start_i <= bracket_index_i))
    else $error("window start beyond bracketing index");

  // A size error carries no search result.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && size_error_i |->
      (window_start_i == '0) && (bracket_index_i == '0) && !used_hunt_i)
    else $error("size error result carries search fields");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn before it was taken");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(window_start_i) && $stable(bracket_index_i)
      && $stable(used_hunt_i) && $stable(size_error_i))
    else $error("stalled result changed");

endmodule

bind ordered_table_hunt_search_top oths_checker u_oths_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_func_i      (req_i.data.func),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .window_start_i  (rsp_o.data.window_start),
  .bracket_index_i (rsp_o.data.bracket_index),
  .used_hunt_i     (rsp_o.data.used_hunt),
  .size_error_i    (rsp_o.data.size_error)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the ordered table hunt search
// Loads ordered key tables of many sizes, runs correlated and scattered
// queries under random back-pressure and checks every response in order
// against a behavioral hunt-and-bisection search kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import oths_pkg::*;

  localparam int unsigned DEPTH         = DEFAULT_TABLE_DEPTH;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam int unsigned ITEM_TARGET   = 1350;
  localparam int unsigned BIG_TABLE     = 256;
  localparam int unsigned TAIL_ITEMS    = BIG_TABLE + 100;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  class bracket_scoreboard;
    logic signed [KEY_W-1:0] keys [DEPTH];
    int unsigned tbl_n;
    int unsigned win_m;
    int unsigned corr_lim;
    int          saved_idx;
    bit          corr_flag;
    rsp_t        pending_brackets [$];
    int unsigned fail_count;

    function new();
      tbl_n      = TABLE_SIZE_RST;
      win_m      = WINDOW_POINTS_RST;
      corr_lim   = CORR_LIMIT_RST;
      saved_idx  = 0;
      corr_flag  = 1'b0;
      fail_count = 0;
    endfunction

    function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_TABLE_SIZE:    tbl_n = value[SIZE_W-1:0];
        CFG_WINDOW_POINTS: win_m = value[SIZE_W-1:0];
        CFG_CORR_LIMIT:    corr_lim = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // True when the key lies at or beyond entry i in table order.
    function bit at_or_past(input logic signed [KEY_W-1:0] x, input int i, input bit asc);
      return (x >= keys[i]) == asc;
    endfunction

    function void note_request(input req_t rq);
      logic signed [KEY_W-1:0] x;
      int   n, m, jl, ju, jm, inc, d, ws;
      bit   asc, hunted;
      rsp_t r;
      x = rq.key_value;
      if (rq.func == FUNC_WRITE) begin
        keys[rq.entry_index] = x;
        return;
      end
      n = int'(tbl_n);
      m = int'(win_m);
      r = '0;
      if (n < 2 || m < 2 || m > n || n > int'(DEPTH)) begin
        r.size_error = 1'b1;
        pending_brackets.push_back(r);
        return;
      end
      asc    = keys[n-1] >= keys[0];
      hunted = 1'b0;
      jl     = 0;
      ju     = n - 1;
      if (corr_flag && saved_idx <= n - 1) begin
        hunted = 1'b1;
        jl     = saved_idx;
        inc    = 1;
        if (at_or_past(x, jl, asc)) begin
          while (1) begin
            ju = jl + inc;
            if (ju >= n - 1) begin
              ju = n - 1;
              break;
            end
            if (!at_or_past(x, ju, asc)) break;
            jl  = ju;
            inc = inc + inc;
          end
        end else begin
          ju = jl;
          while (1) begin
            jl = jl - inc;
            if (jl <= 0) begin
              jl = 0;
              break;
            end
            if (at_or_past(x, jl, asc)) break;
            ju  = jl;
            inc = inc + inc;
          end
        end
      end
      while (ju - jl > 1) begin
        jm = (ju + jl) / 2;
        if (at_or_past(x, jm, asc)) jl = jm;
        else ju = jm;
      end
      d = jl - saved_idx;
      if (d < 0) d = -d;
      corr_flag = (d > int'(corr_lim)) ? 1'b0 : 1'b1;
      saved_idx = jl;
      ws = jl - ((m - 2) / 2);
      if (ws > n - m) ws = n - m;
      if (ws < 0) ws = 0;
      r.window_start  = ENTRY_W'(ws);
      r.bracket_index = ENTRY_W'(jl);
      r.used_hunt     = hunted;
      pending_brackets.push_back(r);
    endfunction

    function void check_response(input rsp_t got);
      rsp_t want;
      if (pending_brackets.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("response with no query pending: start %0d index %0d hunt %0b err %0b",
                   got.window_start, got.bracket_index, got.used_hunt, got.size_error);
        return;
      end
      want = pending_brackets.pop_front();
      if (got.window_start !== want.window_start || got.bracket_index !== want.bracket_index ||
          got.used_hunt !== want.used_hunt || got.size_error !== want.size_error) begin
        fail_count++;
        if (fail_count <= 10)
          $display("bracket mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                   want.window_start, want.bracket_index, want.used_hunt, want.size_error,
                   got.window_start, got.bracket_index, got.used_hunt, got.size_error);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned src_idle_pct  = 12;
  int unsigned sink_idle_pct = 88;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;

  bracket_scoreboard sb = new();

  oths_stream_if #(.payload_t(req_t)) req_if ();
  oths_stream_if #(.payload_t(rsp_t)) rsp_if ();
  oths_stream_if #(.payload_t(cfg_t)) cfg_if ();

  ordered_table_hunt_search_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    rsp_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Valid is left high after a transaction so that a back-to-back item never
  // sees it lowered and raised within one time step.
  task automatic send_request(input req_t rq);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(rq);
    items_sent++;
  endtask

  task automatic store_key(input int idx, input logic signed [KEY_W-1:0] k);
    req_t rq;
    rq.func        = FUNC_WRITE;
    rq.entry_index = ENTRY_W'(idx);
    rq.key_value   = k;
    send_request(rq);
  endtask

  task automatic make_query(input logic signed [KEY_W-1:0] k);
    req_t rq;
    rq.func        = FUNC_QUERY;
    rq.entry_index = ENTRY_W'($urandom);
    rq.key_value   = k;
    send_request(rq);
  endtask

  // Holds off the sender until every pending response has come, then lets a
  // trailing write finish before anything else happens.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_brackets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_t c;
    c.reg_index = idx;
    c.reg_value = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_register(idx, value);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Register value with random bits above the field, half of the time.
  function automatic logic [CFG_DATA_W-1:0] junk_bits(input int v, input int w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (32'd1 << w) - 32'd1;
    if ($urandom_range(1, 0) == 0) return CFG_DATA_W'(v);
    return ($urandom & ~mask) | (CFG_DATA_W'(v) & mask);
  endfunction

  task automatic configure(input int n, input int m, input int lim);
    write_reg(CFG_TABLE_SIZE, junk_bits(n, SIZE_W));
    write_reg(CFG_WINDOW_POINTS, junk_bits(m, SIZE_W));
    write_reg(CFG_CORR_LIMIT, junk_bits(lim, LIMIT_W));
  endtask

  // Writes entries 0..n-1 with a monotonic run of keys, duplicates included.
  task automatic load_table(input int n, input bit descending, input bit flat);
    longint acc;
    longint span;
    int     i;
    if ($urandom_range(3, 0) == 0) acc = longint'(KEY_MIN);
    else acc = -longint'($urandom_range(32'h7FFF_FFFF, 0));
    span = flat ? 0 : (64'd4294967295 / n);
    for (i = 0; i < n; i++) begin
      store_key(descending ? n - 1 - i : i, KEY_W'(acc));
      if ($urandom_range(9, 0) != 0) acc = acc + longint'($urandom_range(32'(span), 0));
      if (acc > longint'(KEY_MAX)) acc = longint'(KEY_MAX);
    end
  endtask

  // Mostly keys close to the last bracket, so the hunt path gets exercised.
  function automatic logic signed [KEY_W-1:0] pick_key(input int n);
    int idx;
    int roll;
    roll = $urandom_range(99, 0);
    idx  = sb.saved_idx + int'($urandom_range(6, 0)) - 3;
    if (idx < 0) idx = 0;
    if (idx > n - 1) idx = n - 1;
    if (roll < 60) return sb.keys[idx] + KEY_W'(int'($urandom_range(4, 0)) - 2);
    if (roll < 75) return $urandom;
    if (roll < 85) return sb.keys[$urandom_range(n - 1, 0)];
    if (roll < 92) return $urandom_range(1, 0) ? KEY_MIN : KEY_MAX;
    return sb.keys[$urandom_range(n - 1, 0)] + KEY_W'(int'($urandom_range(2, 0)) - 1);
  endfunction

  task automatic set_idling();
    if (items_sent < ITEM_TARGET / 3) begin
      src_idle_pct  = 12;
      sink_idle_pct = 88;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      src_idle_pct  = 88;
      sink_idle_pct = 12;
    end else begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
  endtask

  task automatic run_phase(input int n, input int m, input int lim, input int queries);
    int k;
    int roll;
    bit sizes_ok;
    set_idling();
    settle();
    configure(n, m, lim);
    sizes_ok = (n >= 2 && m >= 2 && m <= n && n <= int'(DEPTH));
    if (sizes_ok) load_table(n, $urandom_range(1, 0), $urandom_range(19, 0) == 0);
    for (k = 0; k < queries; k++) begin
      roll = $urandom_range(99, 0);
      if (roll < 8) store_key($urandom_range(DEPTH - 1, 0), $urandom);
      else if (roll < 10) settle();
      else make_query(sizes_ok ? pick_key(n) : $urandom);
    end
  endtask

  task automatic random_phase();
    int n, m, lim, roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) begin
      case ($urandom_range(3, 0))
        0: begin
          n = $urandom_range(40, 2);
          m = n + $urandom_range(40, 1);
        end
        1: begin
          n = $urandom_range(40, 2);
          m = $urandom_range(1, 0);
        end
        2: begin
          n = $urandom_range(1, 0);
          m = 2;
        end
        default: begin
          n = $urandom_range(4095, DEPTH + 1);
          m = 2;
        end
      endcase
      run_phase(n, m, $urandom_range(2047, 0), 4);
    end else begin
      roll = $urandom_range(99, 0);
      if (roll < 10) n = 2;
      else if (roll < 70) n = $urandom_range(32, 3);
      else if (roll < 90) n = $urandom_range(128, 33);
      else n = $urandom_range(400, 129);
      roll = $urandom_range(99, 0);
      if (roll < 30) m = 2;
      else if (roll < 45) m = n;
      else m = $urandom_range(n, 2);
      roll = $urandom_range(99, 0);
      if (roll < 20) lim = 0;
      else if (roll < 35) lim = 2047;
      else if (roll < 75) lim = $urandom_range(8, 0);
      else lim = $urandom_range(2047, 0);
      run_phase(n, m, lim, $urandom_range(50, 15));
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.data   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ascending table with a duplicate pair and both key extremes.
    set_idling();
    configure(8, 2, 2047);
    write_reg(CFG_UNUSED, $urandom);
    store_key(0, KEY_MIN);
    store_key(1, -1000);
    store_key(2, -1000);
    store_key(3, -1);
    store_key(4, 0);
    store_key(5, 5);
    store_key(6, 1000);
    store_key(7, KEY_MAX);
    make_query(KEY_MIN);
    make_query(KEY_MAX);
    make_query(-1000);
    make_query(0);
    make_query(0);
    make_query(3);

    // Shrinking the table leaves the saved index beyond its end.
    settle();
    configure(4, 4, 1);
    make_query(0);
    make_query(KEY_MAX);

    // Every kind of size error.
    settle();
    write_reg(CFG_WINDOW_POINTS, 5);
    make_query(0);
    settle();
    write_reg(CFG_WINDOW_POINTS, 1);
    make_query(0);
    settle();
    configure(1, 2, 1);
    make_query(0);
    settle();
    write_reg(CFG_TABLE_SIZE, 0);
    make_query(0);
    settle();
    write_reg(CFG_TABLE_SIZE, 32'hFFFF_FFFF);
    make_query(0);

    // Descending order.
    settle();
    configure(4, 2, 0);
    store_key(0, KEY_MAX);
    store_key(1, 7);
    store_key(2, 7);
    store_key(3, KEY_MIN);
    make_query(7);
    make_query(KEY_MIN);
    make_query(8);

    while (items_sent < ITEM_TARGET - TAIL_ITEMS) random_phase();

    // A large table, then the widest window over it.
    run_phase(BIG_TABLE, 2, 2047, 30);
    settle();
    configure(BIG_TABLE, BIG_TABLE, 0);
    repeat (6) make_query(pick_key(BIG_TABLE));

    settle();
    if (sb.fail_count == 0 && sb.pending_brackets.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== ordered_table_hunt_search_top.f =====
sv/oths_pkg.sv
sv/oths_stream_if.sv
sv/ordered_table_hunt_search_top.sv
sv/oths_checker.sv
verif/tb.sv
